@@ src/twmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncated window median filter: shared package
// Sizes, payload word types and the job descriptor passed from the front
// end to the median engine.
// ----------------------------------------------------------------------------
package twmf_pkg;

    localparam int MAX_HALF     = 15;
    localparam int SAMPLE_WIDTH = 24;
    localparam int HALF_W       = 4;
    localparam int WIN_DEPTH    = 2 * MAX_HALF + 1;
    localparam int IDX_W        = $clog2(WIN_DEPTH);
    localparam int CNT_W        = $clog2(WIN_DEPTH + 1);
    localparam int JQ_DEPTH     = 4;
    localparam int JQ_PTR_W     = $clog2(JQ_DEPTH);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef sample_t [WIN_DEPTH-1:0] win_t;

    typedef struct packed {
        sample_t sample;
        logic    last;
    } in_word_t;

    typedef struct packed {
        sample_t median;
        logic    last_out;
    } out_word_t;

    // Inclusive window bounds as distances behind the newest sample.
    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic             last_out;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } jq_status_t;

endpackage

@@ src/twmf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncated window median filter: front end
// Accepts input words, keeps the sample window and the stream count, holds
// the half width register and issues one job per owed result.
// ----------------------------------------------------------------------------
module twmf_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  twmf_pkg::in_word_t               item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [twmf_pkg::HALF_W-1:0]      cfg_data,
    input  twmf_pkg::jq_status_t             jq_status,
    input  logic                             back_busy,
    output logic                             job_push,
    output twmf_pkg::job_t                   job,
    output twmf_pkg::win_t                   window
);
    import twmf_pkg::*;

    typedef enum logic {
        F_IDLE,
        F_EMIT
    } fstate_t;

    fstate_t           state_reg;
    logic [HALF_W-1:0] half_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  off_reg;
    logic [IDX_W-1:0]  h_reg;
    logic [IDX_W-1:0]  top_reg;
    logic              flush_reg;
    win_t              win_reg;

    logic              accept;
    logic [IDX_W-1:0]  h_eff;
    logic [IDX_W-1:0]  avail_m1;
    logic [IDX_W-1:0]  start;
    logic [IDX_W:0]    hi_sum;

    assign cfg_ready = 1'b1;
    assign full      = (state_reg != F_IDLE) || !jq_status.empty || back_busy;
    assign accept    = push && !full;
    assign window    = win_reg;
    assign job_push  = (state_reg == F_EMIT) && !jq_status.full;

    always_comb
    begin
        h_eff    = (int'(half_reg) > MAX_HALF) ? IDX_W'(MAX_HALF) : IDX_W'(half_reg);
        // Samples held after this one is shifted in, minus one.
        avail_m1 = (cnt_reg < CNT_W'(WIN_DEPTH)) ? IDX_W'(cnt_reg) : IDX_W'(WIN_DEPTH - 1);
        start    = (h_eff < avail_m1) ? h_eff : avail_m1;

        hi_sum       = {1'b0, off_reg} + {1'b0, h_reg};
        job.lo       = (off_reg > h_reg) ? (off_reg - h_reg) : '0;
        job.hi       = (hi_sum > {1'b0, top_reg}) ? top_reg : IDX_W'(hi_sum);
        job.last_out = flush_reg && (off_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            half_reg  <= '0;
            cnt_reg   <= '0;
            off_reg   <= '0;
            h_reg     <= '0;
            top_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                half_reg <= cfg_data;
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        h_reg   <= h_eff;
                        top_reg <= avail_m1;
                        if (item.last)
                        begin
                            cnt_reg   <= '0;
                            off_reg   <= start;
                            flush_reg <= 1'b1;
                            state_reg <= F_EMIT;
                        end
                        else
                        begin
                            if (cnt_reg < CNT_W'(WIN_DEPTH))
                            begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                            off_reg   <= h_eff;
                            flush_reg <= 1'b0;
                            // The centre of a full half window is available.
                            if (avail_m1 >= h_eff)
                            begin
                                state_reg <= F_EMIT;
                            end
                        end
                    end
                end
                F_EMIT:
                begin
                    if (job_push)
                    begin
                        if (!flush_reg || (off_reg == '0))
                        begin
                            state_reg <= F_IDLE;
                        end
                        else
                        begin
                            off_reg <= off_reg - IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // Newest sample sits at distance zero.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg[WIN_DEPTH-1:1] <= win_reg[WIN_DEPTH-2:0];
            win_reg[0]             <= item.sample;
        end
    end

endmodule

@@ src/twmf_jobq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncated window median filter: job queue
// Small first-in first-out buffer of job descriptors between the front end
// and the median engine.
// ----------------------------------------------------------------------------
module twmf_jobq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  twmf_pkg::job_t       job_in,
    input  logic                 pop,
    output twmf_pkg::job_t       job_out,
    output twmf_pkg::jq_status_t status
);
    import twmf_pkg::*;

    job_t                mem_reg [JQ_DEPTH];
    logic [JQ_PTR_W-1:0] wr_ptr_reg;
    logic [JQ_PTR_W-1:0] rd_ptr_reg;
    logic [JQ_PTR_W:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == (JQ_PTR_W + 1)'(JQ_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign job_out      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + JQ_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + JQ_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (JQ_PTR_W + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (JQ_PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

@@ src/twmf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncated window median filter: median engine
// Scans candidates of a job's window one per cycle, ranks each against the
// whole window in parallel and holds the selected median for the output.
// ----------------------------------------------------------------------------
module twmf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  twmf_pkg::job_t      job,
    input  logic                jq_empty,
    output logic                job_pop,
    input  twmf_pkg::win_t      window,
    output logic                busy,
    input  logic                pop,
    output logic                empty,
    output twmf_pkg::out_word_t result
);
    import twmf_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_WAIT
    } bstate_t;

    bstate_t              state_reg;
    logic [IDX_W-1:0]     lo_reg;
    logic [IDX_W-1:0]     hi_reg;
    logic [CNT_W-1:0]     rank_reg;
    logic                 last_reg;
    logic [IDX_W-1:0]     j_reg;
    logic [WIN_DEPTH-1:0] less_mask_reg;
    logic [WIN_DEPTH-1:0] eq_mask_reg;
    sample_t              cand_reg;
    logic                 chk_reg;
    sample_t              res_reg;
    logic                 out_valid_reg;
    out_word_t            out_reg;

    sample_t              cand;
    logic [WIN_DEPTH-1:0] less_mask;
    logic [WIN_DEPTH-1:0] eq_mask;
    logic [CNT_W-1:0]     less_cnt;
    logic [CNT_W-1:0]     eq_cnt;
    logic [CNT_W:0]       upper;
    logic                 hit;
    logic [CNT_W-1:0]     span;
    logic                 out_free;

    assign job_pop  = (state_reg == B_IDLE) && !jq_empty;
    assign busy     = (state_reg != B_IDLE);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign out_free = !out_valid_reg || pop;
    assign cand     = window[j_reg];
    assign span     = CNT_W'(job.hi - job.lo) + CNT_W'(1);

    always_comb
    begin
        for (int k = 0; k < WIN_DEPTH; k++)
        begin
            less_mask[k] = (IDX_W'(k) >= lo_reg) && (IDX_W'(k) <= hi_reg)
                           && ($signed(window[k]) < $signed(cand));
            eq_mask[k]   = (IDX_W'(k) >= lo_reg) && (IDX_W'(k) <= hi_reg)
                           && ($signed(window[k]) == $signed(cand));
        end
    end

    // The candidate is the median when the rank falls inside its run of
    // equal values.
    always_comb
    begin
        less_cnt = CNT_W'($countones(less_mask_reg));
        eq_cnt   = CNT_W'($countones(eq_mask_reg));
        upper    = {1'b0, less_cnt} + {1'b0, eq_cnt};
        hit      = chk_reg && (less_cnt <= rank_reg) && ({1'b0, rank_reg} < upper);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            lo_reg        <= '0;
            hi_reg        <= '0;
            rank_reg      <= '0;
            last_reg      <= 1'b0;
            j_reg         <= '0;
            less_mask_reg <= '0;
            eq_mask_reg   <= '0;
            cand_reg      <= '0;
            chk_reg       <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_pop)
                    begin
                        lo_reg    <= job.lo;
                        hi_reg    <= job.hi;
                        rank_reg  <= span >> 1;
                        last_reg  <= job.last_out;
                        j_reg     <= job.lo;
                        chk_reg   <= 1'b0;
                        state_reg <= B_SCAN;
                    end
                end
                B_SCAN:
                begin
                    less_mask_reg <= less_mask;
                    eq_mask_reg   <= eq_mask;
                    cand_reg      <= cand;
                    chk_reg       <= 1'b1;
                    if (j_reg != hi_reg)
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                    if (hit)
                    begin
                        res_reg   <= cand_reg;
                        chk_reg   <= 1'b0;
                        state_reg <= B_WAIT;
                    end
                end
                B_WAIT:
                begin
                    if (out_free)
                    begin
                        out_reg.median   <= res_reg;
                        out_reg.last_out <= last_reg;
                        out_valid_reg    <= 1'b1;
                        state_reg        <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/truncated_window_median_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncated window median filter: top level
// Running median over a window of up to 2*MAX_HALF+1 samples that shrinks at
// both ends of each stream.
// ----------------------------------------------------------------------------
// Usage: push samples with last marking the end of a stream; results appear
// h words behind the input, and the last word flushes all owed results.
// One word is in work at a time. Each result is found by ranking window
// candidates one per cycle against the whole window, so its cost is set by
// how far the median sits from the newest window edge; an ordinary word
// costs one result and a last word up to h+1 results. full is also high
// while the front end is issuing jobs. A finished result waits in the
// output register while the next word is taken. The half width register is
// always ready and should be written only while the filter is idle.
// ----------------------------------------------------------------------------
module truncated_window_median_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  twmf_pkg::in_word_t          item,
    output logic                        empty,
    input  logic                        pop,
    output twmf_pkg::out_word_t         result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [twmf_pkg::HALF_W-1:0] cfg_data
);
    import twmf_pkg::*;

    jq_status_t jq_status;
    logic       back_busy;
    logic       job_push;
    logic       job_pop;
    job_t       job_in;
    job_t       job_head;
    win_t       window;

    twmf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .jq_status (jq_status),
        .back_busy (back_busy),
        .job_push  (job_push),
        .job       (job_in),
        .window    (window)
    );

    twmf_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (job_in),
        .pop     (job_pop),
        .job_out (job_head),
        .status  (jq_status)
    );

    twmf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job_head),
        .jq_empty (jq_status.empty),
        .job_pop  (job_pop),
        .window   (window),
        .busy     (back_busy),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

@@ test/twmf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncated window median filter: result checker
// Watches the sample, result and half width channels of the filter, keeps
// its own running window and turns every accepted sample word into the
// medians it releases. Each popped result word is compared field by field
// with the oldest predicted median.
// ----------------------------------------------------------------------------
module twmf_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  twmf_pkg::in_word_t          item,
    input  logic                        empty,
    input  logic                        pop,
    input  twmf_pkg::out_word_t         result,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [twmf_pkg::HALF_W-1:0] cfg_data,
    output int                          failures,
    output int                          pending,
    output int                          samples_seen,
    output int                          results_seen,
    output int                          streams_seen
);
    import twmf_pkg::*;

    sample_t           win [WIN_DEPTH];
    int                fill;
    logic [HALF_W-1:0] half_cfg;
    out_word_t         median_q [$];

    initial
    begin
        failures     = 0;
        pending      = 0;
        samples_seen = 0;
        results_seen = 0;
        streams_seen = 0;
        fill         = 0;
        half_cfg     = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        failures++;
    endtask

    // Median of the window around the position off words behind the newest
    // sample, clipped to the samples held for the current stream.
    function automatic sample_t window_median(input int off, input int h, input int avail);
        int lo;
        int hi;
        int rank;
        int less;
        int same;
        int j;
        int k;
        lo = (off > h) ? off - h : 0;
        hi = off + h;
        if (hi > avail - 1)
            hi = avail - 1;
        rank = (hi - lo + 1) / 2;
        for (j = lo; j <= hi; j++)
        begin
            less = 0;
            same = 0;
            for (k = lo; k <= hi; k++)
            begin
                if (win[k] < win[j])
                    less++;
                else if (win[k] == win[j])
                    same++;
            end
            if (less <= rank && rank < less + same)
                return win[j];
        end
        return win[lo];
    endfunction

    task automatic predict_medians(input in_word_t w);
        int        h;
        int        start;
        int        off;
        int        j;
        out_word_t r;
        h = (int'(half_cfg) > MAX_HALF) ? MAX_HALF : int'(half_cfg);
        for (j = WIN_DEPTH - 1; j > 0; j--)
            win[j] = win[j - 1];
        win[0] = w.sample;
        if (fill < WIN_DEPTH)
            fill++;
        samples_seen++;
        if (!w.last)
        begin
            if (fill - 1 >= h)
            begin
                r.median   = window_median(h, h, fill);
                r.last_out = 1'b0;
                median_q   = {median_q, r};
            end
        end
        else
        begin
            // The last word releases every owed position, oldest first.
            start = (h < fill - 1) ? h : fill - 1;
            for (off = start; off >= 0; off--)
            begin
                r.median   = window_median(off, h, fill);
                r.last_out = (off == 0);
                median_q   = {median_q, r};
            end
            fill = 0;
            streams_seen++;
        end
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        if (median_q.size() == 0)
        begin
            report_mismatch($sformatf("result word %0d with no median expected",
                                      results_seen));
        end
        else
        begin
            want = median_q.pop_front();
            if (got.median !== want.median)
                report_mismatch($sformatf("result %0d median %0d, expected %0d",
                                          results_seen, got.median, want.median));
            if (got.last_out !== want.last_out)
                report_mismatch($sformatf("result %0d last_out %b, expected %b",
                                          results_seen, got.last_out, want.last_out));
        end
        results_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill     = 0;
            half_cfg = '0;
            median_q.delete();
            pending  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                half_cfg = cfg_data;
            // Compare before predicting: a word taken at this edge cannot
            // already have its median on the output.
            if (pop && !empty)
                check_result(result);
            if (push && !full)
                predict_medians(item);
            pending = median_q.size();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Truncated window median filter: testbench top
// Drives sample streams and half width changes into the filter, pops its
// results with random stalls, and gives the verdict from the failure and
// pending counts of the checker that sits beside the filter.
// ----------------------------------------------------------------------------
module testbench;
    import twmf_pkg::*;

    localparam int      DRAIN_CYCLES = 600;
    localparam int      HOLD_CYCLES  = 400;
    localparam int      PHASES       = 10;
    localparam int      PHASE_WORDS  = 20;
    localparam sample_t SAMPLE_MAX   = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SAMPLE_MIN   = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    in_word_t          item;
    logic              empty;
    logic              pop;
    out_word_t         result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [HALF_W-1:0] cfg_data;

    logic steady;
    logic hold_request;
    logic held;
    int   failures;
    int   pending;
    int   samples_seen;
    int   results_seen;
    int   streams_seen;

    truncated_window_median_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    twmf_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .empty        (empty),
        .pop          (pop),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .pending      (pending),
        .samples_seen (samples_seen),
        .results_seen (results_seen),
        .streams_seen (streams_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: random stalls, one long hold while the sender keeps going.
    initial
    begin
        held = 1'b0;
        pop  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            pop <= steady || ($urandom_range(99) >= 27);
        end
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with push still high.
    task automatic send_word(input sample_t s, input logic l);
        in_word_t w;
        w.sample = s;
        w.last   = l;
        while (!steady && $urandom_range(99) < 27)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // The half width is only changed once every owed median is out and the
    // filter has had time to finish words that release none.
    task automatic set_half(input logic [HALF_W-1:0] h);
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= h;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                p;
        int                i;
        int                len;
        int                budget;
        int                v;
        logic              close;
        logic [31:0]       raw;
        logic [HALF_W-1:0] h;
        sample_t           s;

        rst_n        = 1'b0;
        push         = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Pass-through with the sample extremes.
        set_half(4'd0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(24'sd0, 1'b0);
        send_word(-24'sd1, 1'b1);

        // Widest window on a stream shorter than it, then a one-word stream.
        set_half(4'd15);
        send_word(24'sd5, 1'b0);
        send_word(-24'sd5, 1'b0);
        send_word(24'sd0, 1'b1);
        send_word(24'sd7, 1'b1);

        // Ties and extremes inside a narrow window.
        set_half(4'd2);
        send_word(24'sd100, 1'b0);
        send_word(24'sd100, 1'b0);
        send_word(SAMPLE_MIN, 1'b0);
        send_word(SAMPLE_MAX, 1'b0);
        send_word(24'sd100, 1'b0);
        send_word(-24'sd3, 1'b1);

        // Half width narrowed in the middle of a stream.
        set_half(4'd3);
        for (i = 1; i <= 5; i++)
            send_word(sample_t'(i), 1'b0);
        set_half(4'd1);
        send_word(24'sd9, 1'b0);
        send_word(24'sd8, 1'b0);
        send_word(24'sd7, 1'b1);

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: h = 4'd15;
                1: h = 4'd4;
                2: h = 4'd0;
                3: h = 4'd1;
                5: h = 4'd7;
                6: h = 4'd15;
                8: h = 4'd2;
                default: h = HALF_W'($urandom_range(15));
            endcase
            set_half(h);
            if (p == 1)
                hold_request <= 1'b1;
            steady <= (p == 5);
            budget = PHASE_WORDS;
            while (budget > 0)
            begin
                case ($urandom_range(9))
                    0: len = $urandom_range(40, 25);
                    1, 2: len = $urandom_range(24, 11);
                    default: len = $urandom_range(10, 1);
                endcase
                budget = budget - len;
                // A phase may end with its stream still open, so the next
                // half width takes over in the middle of it.
                close = (budget > 0) || (p == PHASES - 1) || ($urandom_range(2) != 0);
                for (i = 0; i < len; i++)
                begin
                    raw = $urandom();
                    case ($urandom_range(9))
                        0: s = raw[0] ? SAMPLE_MIN : SAMPLE_MAX;
                        1, 2:
                        begin
                            v = $urandom_range(8);
                            v = v - 4;
                            s = v[SAMPLE_WIDTH-1:0];
                        end
                        default: s = raw[SAMPLE_WIDTH-1:0];
                    endcase
                    send_word(s, close && (i == len - 1));
                end
            end
        end

        push   <= 1'b0;
        steady <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d samples in %0d closed streams, %0d medians checked,",
                 samples_seen, streams_seen, results_seen);
        $display("half widths 0 to 15 with mid-stream changes and a long output stall.");
        if (pending != 0)
            $display("%0d expected medians never arrived", pending);
        if (failures == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
src/twmf_pkg.sv
src/twmf_front.sv
src/twmf_jobq.sv
src/twmf_back.sv
src/truncated_window_median_filter.sv
test/twmf_checker.sv
test/testbench.sv
